// File: hw/rtl/three_level_she_pwm_gate_generator_top_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef THREE_LEVEL_SHE_PWM_GATE_GENERATOR_TOP_MACROS_SVH
`define THREE_LEVEL_SHE_PWM_GATE_GENERATOR_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TLSP_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TLSP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tlsp_pkg.sv
package tlsp_pkg;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SECOND = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_THIRD  = 2'd2;

  localparam logic signed [1:0] LVL_POS  = 2'sb01;
  localparam logic signed [1:0] LVL_ZERO = 2'sb00;
  localparam logic signed [1:0] LVL_NEG  = 2'sb11;

  // NPC gate patterns, bit 3 is S1 down to bit 0 S4.
  localparam logic [3:0] GATES_POS  = 4'b1100;
  localparam logic [3:0] GATES_ZERO = 4'b0110;
  localparam logic [3:0] GATES_NEG  = 4'b0011;

  localparam int COUNT_BITS = 32;

  typedef struct packed {
    logic signed [1:0] level;
    logic [3:0]        gates;
  } phase_out_t;

endpackage

// File: hw/rtl/tlsp_in_if.sv
interface tlsp_in_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] ref_angle;

  modport source (output valid, output ref_angle, input ready);
  modport sink (input valid, input ref_angle, output ready);
endinterface

// File: hw/rtl/tlsp_out_if.sv
interface tlsp_out_if ();
  logic              valid;
  logic              ready;
  logic signed [1:0] phase_a_level;
  logic signed [1:0] phase_b_level;
  logic signed [1:0] phase_c_level;
  logic [3:0]        phase_a_gates;
  logic [3:0]        phase_b_gates;
  logic [3:0]        phase_c_gates;
  logic [31:0]       phase_a_switch_count;

  modport source (
    output valid, output phase_a_level, output phase_b_level, output phase_c_level,
    output phase_a_gates, output phase_b_gates, output phase_c_gates,
    output phase_a_switch_count, input ready
  );
  modport sink (
    input valid, input phase_a_level, input phase_b_level, input phase_c_level,
    input phase_a_gates, input phase_b_gates, input phase_c_gates,
    input phase_a_switch_count, output ready
  );
endinterface

// File: hw/rtl/tlsp_cfg_if.sv
interface tlsp_cfg_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [ANGLE_BITS-2:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tlsp_cfg_regs.sv
module tlsp_cfg_regs
  import tlsp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [ANGLE_BITS-2:0]     wr_data,
  output logic [ANGLE_BITS-2:0]     angle_first,
  output logic [ANGLE_BITS-2:0]     angle_second,
  output logic [ANGLE_BITS-2:0]     angle_third
);

  localparam int CW = ANGLE_BITS - 1;
  localparam int UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int DN = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

  // Reset angles are given for 16-bit turns and rescaled to the configured width.
  localparam logic [CW-1:0] RST_FIRST  = CW'((64'd5321 << UP) >> DN);
  localparam logic [CW-1:0] RST_SECOND = CW'((64'd7144 << UP) >> DN);
  localparam logic [CW-1:0] RST_THIRD  = CW'((64'd9559 << UP) >> DN);

  logic [CW-1:0] first_r;
  logic [CW-1:0] second_r;
  logic [CW-1:0] third_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= RST_FIRST;
      second_r <= RST_SECOND;
      third_r  <= RST_THIRD;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IDX_FIRST:  first_r  <= wr_data;
        CFG_IDX_SECOND: second_r <= wr_data;
        CFG_IDX_THIRD:  third_r  <= wr_data;
        default: ;
      endcase
    end
  end

  assign angle_first  = first_r;
  assign angle_second = second_r;
  assign angle_third  = third_r;

endmodule

// File: hw/rtl/tlsp_phase_eval.sv
module tlsp_phase_eval
  import tlsp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic [ANGLE_BITS-1:0] angle,
  input  logic [ANGLE_BITS-2:0] angle_first,
  input  logic [ANGLE_BITS-2:0] angle_second,
  input  logic [ANGLE_BITS-2:0] angle_third,
  output phase_out_t            phase
);

  logic                  neg;
  logic [ANGLE_BITS-3:0] fold;
  logic [ANGLE_BITS-2:0] fold_ext;
  logic                  odd;

  // The top bit picks the half turn. In the second quarter of a half turn,
  // mirroring about the quarter point is an inversion of the low bits.
  assign neg      = angle[ANGLE_BITS-1];
  assign fold     = angle[ANGLE_BITS-2] ? ~angle[ANGLE_BITS-3:0] : angle[ANGLE_BITS-3:0];
  assign fold_ext = {1'b0, fold};
  assign odd      = (fold_ext >= angle_first) ^ (fold_ext >= angle_second)
                  ^ (fold_ext >= angle_third);

  always_comb begin
    if (!odd) begin
      phase.level = LVL_ZERO;
      phase.gates = GATES_ZERO;
    end else if (neg) begin
      phase.level = LVL_NEG;
      phase.gates = GATES_NEG;
    end else begin
      phase.level = LVL_POS;
      phase.gates = GATES_POS;
    end
  end

endmodule

// File: hw/rtl/tlsp_switch_counter.sv
module tlsp_switch_counter
  import tlsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [3:0]            gates_a,
  output logic [COUNT_BITS-1:0] count
);

  logic [3:0]            last_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [3:0]            flips;
  logic [2:0]            flip_count;
  logic [COUNT_BITS:0]   sum;

  assign flips      = gates_a ^ last_r;
  assign flip_count = {2'b00, flips[0]} + {2'b00, flips[1]} + {2'b00, flips[2]}
                    + {2'b00, flips[3]};
  assign sum        = {1'b0, count_r} + {{(COUNT_BITS-2){1'b0}}, flip_count};
  // A carry out of the total pins it at all ones.
  assign count_nxt = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 4'b0000;
      count_r <= '0;
    end else if (load) begin
      last_r  <= gates_a;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// File: hw/rtl/three_level_she_pwm_gate_generator_top.sv
// Three-level NPC gate generator with selective harmonic elimination angles.
// in_ch carries one reference angle per item (2^ANGLE_BITS units per turn).
// out_ch returns one item per input: the levels and NPC gate patterns of
// phases A, B and C, and the saturating total of phase A gate transitions.
// cfg_ch writes the three switching angles by index 0, 1 and 2; other indexes are
// ignored. cfg_ch is always ready; the user must write it while idle (unchecked).
// An item is accepted into the input register and then moves to the result register,
// from which its result is offered.
// One item is accepted every cycle while out_ch does not stall; the rate is set by
// the two-register pipeline with level comparison between them.
// When out_ch stalls, the result register holds and the input register
// fills; in_ch.ready drops only when both are occupied.
// Synchronous reset empties the pipeline, restores the default angles and
// clears the last phase A pattern and the transition total.
module three_level_she_pwm_gate_generator_top
  import tlsp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tlsp_in_if.sink    in_ch,
  tlsp_out_if.source out_ch,
  tlsp_cfg_if.sink   cfg_ch
);

  localparam logic [ANGLE_BITS-1:0] OFF_C =
    ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 3);
  localparam logic [ANGLE_BITS-1:0] OFF_B =
    ANGLE_BITS'(((64'd2 << ANGLE_BITS) + 64'd1) / 3);

  logic [ANGLE_BITS-2:0] angle_first;
  logic [ANGLE_BITS-2:0] angle_second;
  logic [ANGLE_BITS-2:0] angle_third;

  logic                  s1_valid_r;
  logic [ANGLE_BITS-1:0] s1_angle_r;
  logic                  s2_valid_r;
  logic                  s1_ready;
  logic                  s2_ready;
  logic                  s2_load;

  logic [ANGLE_BITS-1:0] angle_b;
  logic [ANGLE_BITS-1:0] angle_c;
  phase_out_t            phase_a;
  phase_out_t            phase_b;
  phase_out_t            phase_c;
  phase_out_t            res_a_r;
  phase_out_t            res_b_r;
  phase_out_t            res_c_r;
  logic [COUNT_BITS-1:0] count;

  assign cfg_ch.ready = 1'b1;

  tlsp_cfg_regs #(.ANGLE_BITS(ANGLE_BITS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_ch.valid),
    .wr_index     (cfg_ch.index),
    .wr_data      (cfg_ch.data),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .angle_third  (angle_third)
  );

  assign s2_ready    = !s2_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign s2_load     = s1_valid_r && s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_angle_r <= in_ch.ref_angle;
    end
  end

  assign angle_b = s1_angle_r + OFF_B;
  assign angle_c = s1_angle_r + OFF_C;

  tlsp_phase_eval #(.ANGLE_BITS(ANGLE_BITS)) u_eval_a (
    .angle        (s1_angle_r),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .angle_third  (angle_third),
    .phase        (phase_a)
  );

  tlsp_phase_eval #(.ANGLE_BITS(ANGLE_BITS)) u_eval_b (
    .angle        (angle_b),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .angle_third  (angle_third),
    .phase        (phase_b)
  );

  tlsp_phase_eval #(.ANGLE_BITS(ANGLE_BITS)) u_eval_c (
    .angle        (angle_c),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .angle_third  (angle_third),
    .phase        (phase_c)
  );

  // The transition total is updated exactly when an item enters the result register.
  tlsp_switch_counter u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s2_load),
    .gates_a (phase_a.gates),
    .count   (count)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      res_a_r <= phase_a;
      res_b_r <= phase_b;
      res_c_r <= phase_c;
    end
  end

  assign out_ch.valid                = s2_valid_r;
  assign out_ch.phase_a_level        = res_a_r.level;
  assign out_ch.phase_b_level        = res_b_r.level;
  assign out_ch.phase_c_level        = res_c_r.level;
  assign out_ch.phase_a_gates        = res_a_r.gates;
  assign out_ch.phase_b_gates        = res_b_r.gates;
  assign out_ch.phase_c_gates        = res_c_r.gates;
  assign out_ch.phase_a_switch_count = count;

endmodule

// File: hw/rtl/tlsp_checker.sv
`include "three_level_she_pwm_gate_generator_top_macros.svh"

module tlsp_checker
  import tlsp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] a_level,
  input logic [3:0]        a_gates,
  input logic [31:0]       a_count
);

  logic stalled;
  logic a_pair_ok;

  assign stalled   = out_valid && !out_ready;
  assign a_pair_ok = (a_level == LVL_POS && a_gates == GATES_POS)
                   || (a_level == LVL_ZERO && a_gates == GATES_ZERO)
                   || (a_level == LVL_NEG && a_gates == GATES_NEG);

  `TLSP_ASSERT_CLK(a_out_hold, stalled |=> out_valid, "result item dropped while stalled")

  `TLSP_ASSERT_CLK(a_count_hold, stalled |=> $stable(a_count), "stalled count changed")

  // While out_valid is high, phase A gates must agree with the phase A level beside them.
  `TLSP_ASSERT_CLK(a_gates_match, out_valid |-> a_pair_ok, "phase A gates disagree with level")

  // The saturating total never steps backward outside reset.
  `TLSP_ASSERT_CLK(a_count_mono, $past(rst_n) |-> a_count >= $past(a_count), "total decreased")

  `TLSP_ASSERT_RST(a_reset_empty, $past(rst_n) == 1'b0 |-> !out_valid, "valid after reset")

endmodule

bind three_level_she_pwm_gate_generator_top tlsp_checker u_tlsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .a_level   (out_ch.phase_a_level),
  .a_gates   (out_ch.phase_a_gates),
  .a_count   (out_ch.phase_a_switch_count)
);
